/* sv/frac_red_pkg.sv */
// ----------------------------------------------------------------------------
// frac_red_pkg
// Shared types for the fraction reducer: sequencer state encoding.
// ----------------------------------------------------------------------------
package frac_red_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_GCD,
    ST_DIVN,
    ST_DIVD,
    ST_SIGN,
    ST_DONE
  } fr_state_t;

endpackage

/* sv/frac_red_sub.sv */
// ----------------------------------------------------------------------------
// frac_red_sub
// Shared subtract/compare unit: difference, borrow and equality of two
// unsigned operands.
// ----------------------------------------------------------------------------
module frac_red_sub #(
  parameter int DATA_WIDTH = 32
) (
  input  logic [DATA_WIDTH-1:0] op_a,
  input  logic [DATA_WIDTH-1:0] op_b,
  output logic [DATA_WIDTH-1:0] diff,
  output logic                  borrow,
  output logic                  equal
);

  logic [DATA_WIDTH:0] wide;

  assign wide   = {1'b0, op_a} - {1'b0, op_b};
  assign diff   = wide[DATA_WIDTH-1:0];
  assign borrow = wide[DATA_WIDTH];
  assign equal  = (wide == '0);

endmodule

/* sv/fraction_reducer.sv */
// ----------------------------------------------------------------------------
// fraction_reducer
// Brings a signed fraction to lowest terms by dividing both magnitudes by
// their greatest common divisor.
// ----------------------------------------------------------------------------
// One word (numerator_in, denominator_in) is taken at a clock edge where
// start is high and busy is low. The result appears on numerator_out and
// denominator_out for exactly one cycle with done high; the receiver must
// take it then, there is no way to hold it off. Each result keeps the sign
// of its own input, and the most negative input saturates to
// -(2^(DATA_WIDTH-1)-1). If either magnitude is 0 or 1 the values pass
// through as sign and magnitude. A pass-through goes from the load
// straight to the sign step. Otherwise the load is followed by the
// binary gcd (one shift, swap or subtract per cycle), a restoring
// division of the numerator and then of the denominator by the gcd,
// and the sign step. The gcd and the divisions share one subtractor.
// busy drops in the cycle that shows done, so the next word can be
// accepted alongside the result.
// ----------------------------------------------------------------------------
module fraction_reducer #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic signed [DATA_WIDTH-1:0] numerator_in,
  input  logic signed [DATA_WIDTH-1:0] denominator_in,
  output logic                         done,
  output logic signed [DATA_WIDTH-1:0] numerator_out,
  output logic signed [DATA_WIDTH-1:0] denominator_out
);

  import frac_red_pkg::*;

  localparam int KW = $clog2(DATA_WIDTH);
  localparam int CW = $clog2(DATA_WIDTH);
  localparam logic [DATA_WIDTH-1:0] MAG_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam logic [CW-1:0] CNT_LAST = CW'(DATA_WIDTH - 1);

  fr_state_t state, state_next;

  // operand registers
  logic [DATA_WIDTH-1:0] mag_n, mag_d;   // input magnitudes
  logic                  neg_n, neg_d;   // input signs
  logic [DATA_WIDTH-1:0] ga, gb;         // gcd working pair
  logic [KW-1:0]         k;              // common factors of two
  logic [DATA_WIDTH-1:0] g;              // gcd
  logic [DATA_WIDTH-1:0] q, r;           // divider dividend/quotient and remainder
  logic [CW-1:0]         cnt;            // division bit count
  logic [DATA_WIDTH-1:0] quo_n, quo_d;   // reduced magnitudes

  // input magnitudes with saturation of the most negative value
  logic [DATA_WIDTH-1:0] neg_in_n, neg_in_d, mag_in_n, mag_in_d;
  logic                  accept, bypass;

  assign neg_in_n = -numerator_in;
  assign neg_in_d = -denominator_in;
  assign mag_in_n = !numerator_in[DATA_WIDTH-1] ? numerator_in :
                    (neg_in_n[DATA_WIDTH-1] ? MAG_MAX : neg_in_n);
  assign mag_in_d = !denominator_in[DATA_WIDTH-1] ? denominator_in :
                    (neg_in_d[DATA_WIDTH-1] ? MAG_MAX : neg_in_d);

  assign accept = start && !busy;
  // 0 or 1 on either side: nothing to reduce
  assign bypass = (mag_in_n[DATA_WIDTH-1:1] == '0) || (mag_in_d[DATA_WIDTH-1:1] == '0);

  // shared subtractor: gcd compare/subtract or restoring division trial
  logic [DATA_WIDTH-1:0] r_shift, sub_a, sub_b, sub_diff, q_next;
  logic                  sub_borrow, sub_equal;

  assign r_shift = {r[DATA_WIDTH-2:0], q[DATA_WIDTH-1]};
  assign sub_a   = (state == ST_GCD) ? ga : r_shift;
  assign sub_b   = (state == ST_GCD) ? gb : g;
  assign q_next  = {q[DATA_WIDTH-2:0], !sub_borrow};

  frac_red_sub #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_sub (
    .op_a  (sub_a),
    .op_b  (sub_b),
    .diff  (sub_diff),
    .borrow(sub_borrow),
    .equal (sub_equal)
  );

  logic both_odd, gcd_end, cnt_last;

  assign both_odd = ga[0] && gb[0];
  assign gcd_end  = both_odd && sub_equal;
  assign cnt_last = (cnt == CNT_LAST);

  // sequencer: next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE, ST_DONE: begin
        if (accept) begin
          state_next = bypass ? ST_SIGN : ST_GCD;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_GCD: begin
        if (gcd_end) begin
          state_next = ST_DIVN;
        end
      end
      ST_DIVN: begin
        if (cnt_last) begin
          state_next = ST_DIVD;
        end
      end
      ST_DIVD: begin
        if (cnt_last) begin
          state_next = ST_SIGN;
        end
      end
      ST_SIGN: state_next = ST_DONE;
      default: state_next = ST_IDLE;
    endcase
  end

  // sequencer: outputs
  always_comb begin
    busy = 1'b1;
    done = 1'b0;
    case (state)
      ST_IDLE: busy = 1'b0;
      ST_DONE: begin
        busy = 1'b0;
        done = 1'b1;
      end
      default: busy = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE, ST_DONE: begin
        if (accept) begin
          mag_n <= mag_in_n;
          mag_d <= mag_in_d;
          neg_n <= numerator_in[DATA_WIDTH-1];
          neg_d <= denominator_in[DATA_WIDTH-1];
          ga    <= mag_in_n;
          gb    <= mag_in_d;
          k     <= '0;
          quo_n <= mag_in_n;
          quo_d <= mag_in_d;
        end
      end
      ST_GCD: begin
        // binary gcd: one shift, swap or subtract per cycle
        if (!ga[0] && !gb[0]) begin
          ga <= ga >> 1;
          gb <= gb >> 1;
          k  <= k + 1'b1;
        end else if (!ga[0]) begin
          ga <= ga >> 1;
        end else if (!gb[0]) begin
          gb <= gb >> 1;
        end else if (sub_equal) begin
          g   <= ga << k;
          q   <= mag_n;
          r   <= '0;
          cnt <= '0;
        end else if (sub_borrow) begin
          ga <= gb;
          gb <= ga;
        end else begin
          ga <= sub_diff;
        end
      end
      ST_DIVN, ST_DIVD: begin
        if (cnt_last && (state == ST_DIVN)) begin
          // numerator done, load the denominator
          quo_n <= q_next;
          q     <= mag_d;
          r     <= '0;
          cnt   <= '0;
        end else begin
          r   <= sub_borrow ? r_shift : sub_diff;
          q   <= q_next;
          cnt <= cnt + 1'b1;
          if (cnt_last) begin
            quo_d <= q_next;
          end
        end
      end
      ST_SIGN: begin
        numerator_out   <= neg_n ? -quo_n : quo_n;
        denominator_out <= neg_d ? -quo_d : quo_d;
      end
      default: ;
    endcase
  end

endmodule

/* sv/frac_red_chk.sv */
// ----------------------------------------------------------------------------
// frac_red_chk
// Port-level checks for the fraction reducer, bound to the top level.
// ----------------------------------------------------------------------------
module frac_red_chk #(
  parameter int DATA_WIDTH = 32
) (
  input logic                  clk,
  input logic                  rst,
  input logic                  start,
  input logic                  busy,
  input logic                  done,
  input logic [DATA_WIDTH-1:0] numerator_out,
  input logic [DATA_WIDTH-1:0] denominator_out
);

  localparam logic [DATA_WIDTH-1:0] MOST_NEG = {1'b1, {(DATA_WIDTH-1){1'b0}}};

  // result strobe lasts one cycle
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("done held longer than one cycle");

  // an accepted word keeps the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("busy not raised after accept");

  // a result only follows a busy period
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("done without a word in flight");

  // magnitudes saturate, so the most negative code never comes out
  a_no_most_neg: assert property (@(posedge clk) disable iff (rst)
    done |-> (numerator_out != MOST_NEG) && (denominator_out != MOST_NEG))
    else $error("most negative code on result");

endmodule

bind fraction_reducer frac_red_chk #(.DATA_WIDTH(DATA_WIDTH)) u_frac_red_chk (.*);
